>>> rtl/bcdt_pkg.sv
// ----------------------------------------------------------------------------
// BCD timer package
// Digit, counter and state types, event codes and BCD step functions shared
// by the timer's modules.
// ----------------------------------------------------------------------------
package bcdt_pkg;

    typedef logic [3:0] digit_t;
    typedef digit_t [3:0] bcd4_t;

    typedef struct packed {
        bcd4_t up_digits;
        bcd4_t down_digits;
        logic  running;
        logic  alarm_level;
    } timer_state_t;

    typedef struct packed {
        logic  display_write;
        bcd4_t shown;
        logic  alarm;
    } timer_result_t;

    localparam logic       KIND_TICK = 1'b0;
    localparam logic       KIND_KEY  = 1'b1;

    localparam logic [4:0] KEY_RESET    = 5'd1;
    localparam logic [4:0] KEY_UP_TEN   = 5'd2;
    localparam logic [4:0] KEY_DOWN_TEN = 5'd4;
    localparam logic [4:0] KEY_RUN      = 5'd8;

    localparam logic [4:0] MODE_SHOW_UP   = 5'd1;
    localparam logic [4:0] MODE_COUNTDOWN = 5'd2;

    localparam digit_t DIGIT_ZERO = 4'd0;
    localparam digit_t DIGIT_MAX  = 4'd9;
    localparam digit_t DIGIT_ONE  = 4'd1;

    // Adds one at digit position pos and carries upward; the top digit wraps.
    function automatic bcd4_t bcd_inc_from(input bcd4_t d, input int unsigned pos);
        bcd4_t r;
        logic  carry;
        r = d;
        carry = 1'b1;
        for (int unsigned i = 0; i < 4; i++)
        begin
            if (i >= pos && carry)
            begin
                if (r[i] == DIGIT_MAX)
                begin
                    r[i] = DIGIT_ZERO;
                end
                else
                begin
                    r[i] = r[i] + DIGIT_ONE;
                    carry = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // True when some digit from position pos upward is nonzero.
    function automatic logic bcd_can_dec(input bcd4_t d, input int unsigned pos);
        logic any;
        any = 1'b0;
        for (int unsigned i = 0; i < 4; i++)
        begin
            if (i >= pos && d[i] != DIGIT_ZERO)
            begin
                any = 1'b1;
            end
        end
        return any;
    endfunction

    // Subtracts one at digit position pos and borrows upward; the value is
    // left unchanged when all digits from pos upward are zero.
    function automatic bcd4_t bcd_dec_from(input bcd4_t d, input int unsigned pos);
        bcd4_t r;
        logic  borrow;
        r = d;
        borrow = 1'b1;
        for (int unsigned i = 0; i < 4; i++)
        begin
            if (i >= pos && borrow)
            begin
                if (r[i] != DIGIT_ZERO)
                begin
                    r[i] = r[i] - DIGIT_ONE;
                    borrow = 1'b0;
                end
                else
                begin
                    r[i] = DIGIT_MAX;
                end
            end
        end
        if (borrow)
        begin
            r = d;
        end
        return r;
    endfunction

endpackage

>>> rtl/bcdt_step.sv
// ----------------------------------------------------------------------------
// BCD timer event step
// Computes the next counter state and the display result for one tick or
// key event.
// ----------------------------------------------------------------------------
module bcdt_step
    import bcdt_pkg::*;
(
    input  timer_state_t  state,
    input  logic          kind,
    input  logic [4:0]    key_bits,
    input  logic [4:0]    mode_switches,
    output timer_state_t  state_next,
    output timer_result_t result
);

    always_comb
    begin
        state_next = state;
        result = '0;
        if (kind == KIND_TICK)
        begin
            state_next.up_digits = bcd_inc_from(state.up_digits, 0);
            if (mode_switches == MODE_SHOW_UP)
            begin
                result.display_write = 1'b1;
                result.shown = state_next.up_digits;
            end
            else if (mode_switches == MODE_COUNTDOWN)
            begin
                if (state.running)
                begin
                    if (bcd_can_dec(state.down_digits, 0))
                    begin
                        state_next.down_digits = bcd_dec_from(state.down_digits, 0);
                    end
                    else
                    begin
                        state_next.alarm_level = 1'b1;
                    end
                end
                result.display_write = 1'b1;
                result.shown = state_next.down_digits;
            end
            if (bcd_can_dec(state_next.down_digits, 0))
            begin
                state_next.alarm_level = 1'b0;
            end
        end
        else
        begin
            unique case (key_bits)
                KEY_RESET:
                begin
                    state_next.up_digits = '0;
                    state_next.down_digits = '0;
                    state_next.running = 1'b0;
                    result.display_write = 1'b1;
                end
                KEY_UP_TEN:
                begin
                    state_next.down_digits = bcd_inc_from(state.down_digits, 1);
                    result.display_write = 1'b1;
                    result.shown = state_next.down_digits;
                end
                KEY_DOWN_TEN:
                begin
                    state_next.down_digits = bcd_dec_from(state.down_digits, 1);
                    result.display_write = 1'b1;
                    result.shown = state_next.down_digits;
                end
                KEY_RUN:
                begin
                    state_next.running = ~state.running;
                end
                default:
                begin
                    state_next = state;
                end
            endcase
        end
        result.alarm = state_next.alarm_level;
    end

endmodule

>>> rtl/bcd_timer_with_countdown_alarm.sv
// ----------------------------------------------------------------------------
// BCD timer with countdown alarm
// Four-digit BCD up counter and countdown with run flag and alarm, driven by
// tick and key events.
// ----------------------------------------------------------------------------
// The block takes one event transaction per cycle and returns one result
// transaction for each: the event is held in an input register, and the
// counter update and display selection run combinationally between that
// register and the result register. Both stages advance together whenever
// the result register is empty or its transaction is taken, so the sustained
// rate is one event per cycle while the output is not stalled.
module bcd_timer_with_countdown_alarm
    import bcdt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic       kind,
    input  logic [4:0] key_bits,
    input  logic [4:0] mode_switches,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       display_write,
    output logic [3:0] shown_thousands,
    output logic [3:0] shown_hundreds,
    output logic [3:0] shown_tens,
    output logic [3:0] shown_ones,
    output logic       alarm
);

    logic          in_valid_reg;
    logic          kind_reg;
    logic [4:0]    key_bits_reg;
    logic [4:0]    mode_reg;
    timer_state_t  state_reg;
    timer_state_t  state_next;
    timer_result_t step_result;
    logic          res_valid_reg;
    timer_result_t res_reg;
    logic          advance;
    logic          accept;

    assign advance = !res_valid_reg || !result_stall;
    assign item_stall = in_valid_reg && !advance;
    assign accept = item_valid && !item_stall;

    bcdt_step u_step
    (
        .state         (state_reg),
        .kind          (kind_reg),
        .key_bits      (key_bits_reg),
        .mode_switches (mode_reg),
        .state_next    (state_next),
        .result        (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                res_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            key_bits_reg <= key_bits;
            mode_reg <= mode_switches;
        end
        if (advance && in_valid_reg)
        begin
            res_reg <= step_result;
        end
    end

    assign result_valid = res_valid_reg;
    assign display_write = res_reg.display_write;
    assign shown_thousands = res_reg.shown[3];
    assign shown_hundreds = res_reg.shown[2];
    assign shown_tens = res_reg.shown[1];
    assign shown_ones = res_reg.shown[0];
    assign alarm = res_reg.alarm;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BCD timer with countdown alarm testbench
// Feeds tick and key event transactions into the timer and compares every
// result transaction against an in-bench prediction of the up counter, the
// countdown, the run flag and the alarm. Directed events, a long countdown
// climb through its wrap, and weighted random traffic are sent, with random
// idle cycles and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
    import bcdt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct {
        logic       kind;
        logic [4:0] keys;
        logic [4:0] switches;
        bit         wait_drain;
        bit         steady;
    } timer_event_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_stall;
    logic       kind = KIND_TICK;
    logic [4:0] key_bits = '0;
    logic [4:0] mode_switches = '0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic       display_write;
    logic [3:0] shown_thousands;
    logic [3:0] shown_hundreds;
    logic [3:0] shown_tens;
    logic [3:0] shown_ones;
    logic       alarm;

    timer_event_t  event_queue[$];
    timer_result_t predicted_displays[$];
    bit            steady_run = 1'b0;
    int            fail_count = 0;
    int            quiet_cycles = 0;

    int up_count = 0;
    int down_count = 0;
    bit run_flag = 1'b0;
    bit alarm_q = 1'b0;

    bcd_timer_with_countdown_alarm dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .kind            (kind),
        .key_bits        (key_bits),
        .mode_switches   (mode_switches),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .display_write   (display_write),
        .shown_thousands (shown_thousands),
        .shown_hundreds  (shown_hundreds),
        .shown_tens      (shown_tens),
        .shown_ones      (shown_ones),
        .alarm           (alarm)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic bcd4_t digits_of(input int v);
        bcd4_t d;
        d[0] = digit_t'(v % 10);
        d[1] = digit_t'((v / 10) % 10);
        d[2] = digit_t'((v / 100) % 10);
        d[3] = digit_t'(v / 1000);
        return d;
    endfunction

    function automatic timer_result_t predict_display(input logic k, input logic [4:0] keys,
                                                      input logic [4:0] sw);
        timer_result_t r;
        r = '0;
        if (k == KIND_TICK)
        begin
            up_count = (up_count + 1) % 10000;
            if (sw == MODE_SHOW_UP)
            begin
                r.display_write = 1'b1;
                r.shown = digits_of(up_count);
            end
            else if (sw == MODE_COUNTDOWN)
            begin
                if (run_flag)
                begin
                    if (down_count == 0)
                    begin
                        alarm_q = 1'b1;
                    end
                    else
                    begin
                        down_count = down_count - 1;
                    end
                end
                r.display_write = 1'b1;
                r.shown = digits_of(down_count);
            end
            if (down_count != 0)
            begin
                alarm_q = 1'b0;
            end
        end
        else
        begin
            case (keys)
                KEY_RESET:
                begin
                    up_count = 0;
                    down_count = 0;
                    run_flag = 1'b0;
                    r.display_write = 1'b1;
                    r.shown = digits_of(down_count);
                end
                KEY_UP_TEN:
                begin
                    down_count = (down_count + 10) % 10000;
                    r.display_write = 1'b1;
                    r.shown = digits_of(down_count);
                end
                KEY_DOWN_TEN:
                begin
                    if (down_count >= 10)
                    begin
                        down_count = down_count - 10;
                    end
                    r.display_write = 1'b1;
                    r.shown = digits_of(down_count);
                end
                KEY_RUN:
                begin
                    run_flag = !run_flag;
                end
                default:
                begin
                end
            endcase
        end
        r.alarm = alarm_q;
        return r;
    endfunction

    function automatic void post_event(input logic k, input logic [4:0] keys,
                                       input logic [4:0] sw, input bit drain, input bit steady);
        timer_event_t ev;
        ev.kind = k;
        ev.keys = keys;
        ev.switches = sw;
        ev.wait_drain = drain;
        ev.steady = steady;
        event_queue.push_back(ev);
    endfunction

    function automatic logic [4:0] pick_switches();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
        begin
            return MODE_COUNTDOWN;
        end
        else if (r < 7)
        begin
            return MODE_SHOW_UP;
        end
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [4:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            return KEY_UP_TEN;
        end
        else if (r < 60)
        begin
            return KEY_DOWN_TEN;
        end
        else if (r < 80)
        begin
            return KEY_RUN;
        end
        else if (r < 85)
        begin
            return KEY_RESET;
        end
        return 5'($urandom_range(0, 31));
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            kind <= KIND_TICK;
            key_bits <= '0;
            mode_switches <= '0;
            steady_run <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                predicted_displays.push_back(predict_display(kind, key_bits, mode_switches));
            end
            if (!item_valid || !item_stall)
            begin
                if (event_queue.size() != 0
                    && !(event_queue[0].wait_drain && predicted_displays.size() != 0)
                    && (event_queue[0].steady || $urandom_range(0, 99) >= 12))
                begin
                    kind <= event_queue[0].kind;
                    key_bits <= event_queue[0].keys;
                    mode_switches <= event_queue[0].switches;
                    steady_run <= event_queue[0].steady;
                    event_queue.delete(0);
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            result_stall <= !steady_run && ($urandom_range(0, 99) < 12);
            if (result_valid && !result_stall)
            begin
                if (predicted_displays.size() == 0)
                begin
                    $error("Result transaction arrived with no event outstanding.");
                    fail_count++;
                end
                else
                begin
                    want = predicted_displays.pop_front();
                    compare_field("display_write", want.display_write, display_write);
                    compare_field("shown_thousands", want.shown[3], shown_thousands);
                    compare_field("shown_hundreds", want.shown[2], shown_hundreds);
                    compare_field("shown_tens", want.shown[1], shown_tens);
                    compare_field("shown_ones", want.shown[0], shown_ones);
                    compare_field("alarm", want.alarm, alarm);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        bit steady;
        bit drain;
        // Directed events.
        post_event(KIND_TICK, 5'($urandom_range(0, 31)), MODE_SHOW_UP, 0, 0);
        post_event(KIND_TICK, 5'd31, 5'd0, 0, 0);
        post_event(KIND_TICK, 5'd0, 5'd31, 0, 0);
        post_event(KIND_KEY, KEY_DOWN_TEN, 5'd31, 0, 0);
        post_event(KIND_KEY, KEY_UP_TEN, 5'd0, 0, 0);
        post_event(KIND_TICK, 5'($urandom_range(0, 31)), MODE_COUNTDOWN, 0, 0);
        post_event(KIND_KEY, KEY_RUN, 5'($urandom_range(0, 31)), 0, 0);
        post_event(KIND_TICK, 5'($urandom_range(0, 31)), MODE_COUNTDOWN, 0, 0);
        post_event(KIND_KEY, KEY_DOWN_TEN, 5'($urandom_range(0, 31)), 0, 0);
        post_event(KIND_KEY, KEY_RESET, 5'($urandom_range(0, 31)), 0, 0);
        post_event(KIND_KEY, KEY_RUN, 5'($urandom_range(0, 31)), 0, 0);
        post_event(KIND_TICK, 5'($urandom_range(0, 31)), MODE_COUNTDOWN, 0, 0);
        post_event(KIND_TICK, 5'($urandom_range(0, 31)), MODE_COUNTDOWN, 0, 0);
        post_event(KIND_KEY, KEY_RESET, 5'($urandom_range(0, 31)), 0, 0);
        post_event(KIND_TICK, 5'($urandom_range(0, 31)), MODE_SHOW_UP, 0, 0);
        post_event(KIND_KEY, 5'd16, 5'($urandom_range(0, 31)), 0, 0);
        post_event(KIND_KEY, 5'd31, 5'($urandom_range(0, 31)), 0, 0);
        post_event(KIND_KEY, 5'd0, 5'($urandom_range(0, 31)), 0, 0);
        post_event(KIND_KEY, 5'd3, 5'($urandom_range(0, 31)), 0, 0);
        post_event(KIND_KEY, KEY_UP_TEN, 5'($urandom_range(0, 31)), 0, 0);
        post_event(KIND_TICK, 5'($urandom_range(0, 31)), 5'd4, 0, 0);
        post_event(KIND_KEY, KEY_RUN, 5'($urandom_range(0, 31)), 0, 0);
        post_event(KIND_KEY, KEY_RUN, 5'($urandom_range(0, 31)), 0, 0);

        // The countdown climbs to 9999 and past it.
        post_event(KIND_KEY, KEY_RESET, 5'($urandom_range(0, 31)), 1, 0);
        post_event(KIND_KEY, KEY_UP_TEN, 5'($urandom_range(0, 31)), 0, 0);
        post_event(KIND_KEY, KEY_RUN, 5'($urandom_range(0, 31)), 0, 0);
        post_event(KIND_TICK, 5'($urandom_range(0, 31)), MODE_COUNTDOWN, 0, 0);
        post_event(KIND_KEY, KEY_RUN, 5'($urandom_range(0, 31)), 0, 0);
        for (int i = 0; i < 1000; i++)
        begin
            post_event(KIND_KEY, KEY_UP_TEN, 5'($urandom_range(0, 31)), 0, 0);
        end

        for (int n = 0; n < 270; n++)
        begin
            steady = (n >= 60 && n < 180);
            drain = (n == 0 || n == 200);
            if ($urandom_range(0, 99) < 60)
            begin
                post_event(KIND_TICK, 5'($urandom_range(0, 31)), pick_switches(), drain, steady);
            end
            else
            begin
                post_event(KIND_KEY, pick_key(), 5'($urandom_range(0, 31)), drain, steady);
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (event_queue.size() != 0 || item_valid || predicted_displays.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
